// File: rtl/utf8_styled_text_decoder_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the styled UTF-8 text decoder
// Same-cycle and next-cycle implication forms, clocked on clk, muted in reset.
// ---------------------------------------------------------------------------
`ifndef UTF8_STYLED_TEXT_DECODER_ASSERT_SVH
`define UTF8_STYLED_TEXT_DECODER_ASSERT_SVH

// same-cycle implication
`define U8S_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define U8S_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/utf8std_pkg.sv
// ---------------------------------------------------------------------------
// utf8std_pkg
// Constants and the formatting-key decoder for the styled UTF-8 decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package utf8std_pkg;

  localparam int unsigned CP_W     = 21;
  localparam int unsigned COLOUR_W = 4;
  localparam int unsigned STYLE_W  = 4;

  localparam logic [CP_W-1:0]     ESC_CP       = 21'd167;
  localparam logic [COLOUR_W-1:0] COLOUR_WHITE = 4'd15;

  // style_flags bit positions
  localparam int unsigned STY_BOLD      = 0;
  localparam int unsigned STY_STRIKE    = 1;
  localparam int unsigned STY_UNDERLINE = 2;
  localparam int unsigned STY_ITALIC    = 3;

  localparam logic [7:0] CH_UP_A = "A";
  localparam logic [7:0] CH_UP_Z = "Z";
  localparam logic [7:0] CASE_OFS = 8'd32;
  localparam logic [7:0] CH_0 = "0";
  localparam logic [7:0] CH_9 = "9";
  localparam logic [7:0] CH_A = "a";
  localparam logic [7:0] CH_F = "f";
  localparam logic [7:0] CH_K = "k";
  localparam logic [7:0] CH_L = "l";
  localparam logic [7:0] CH_M = "m";
  localparam logic [7:0] CH_N = "n";
  localparam logic [7:0] CH_O = "o";

  typedef enum logic [1:0] {
    KEY_COLOUR,   // set colour, clear styles
    KEY_STYLE,    // OR a style bit in
    KEY_NOP,      // k
    KEY_RESET     // r or unknown: white, no styles
  } key_kind_t;

  typedef struct packed {
    key_kind_t           kind;
    logic [COLOUR_W-1:0] colour;
    logic [STYLE_W-1:0]  style_set;
  } key_act_t;

  function automatic key_act_t decode_key(input logic [7:0] b);
    logic [7:0] c;
    key_act_t   act;
    c = ((b >= CH_UP_A) && (b <= CH_UP_Z)) ? 8'(b + CASE_OFS) : b;
    act.kind      = KEY_RESET;
    act.colour    = COLOUR_WHITE;
    act.style_set = '0;
    if ((c >= CH_0) && (c <= CH_9)) begin
      act.kind   = KEY_COLOUR;
      act.colour = c[3:0];
    end else if ((c >= CH_A) && (c <= CH_F)) begin
      act.kind   = KEY_COLOUR;
      act.colour = 4'(c[3:0] + 4'd9);
    end else if (c == CH_K) begin
      act.kind = KEY_NOP;
    end else if (c == CH_L) begin
      act.kind = KEY_STYLE;
      act.style_set[STY_BOLD] = 1'b1;
    end else if (c == CH_M) begin
      act.kind = KEY_STYLE;
      act.style_set[STY_STRIKE] = 1'b1;
    end else if (c == CH_N) begin
      act.kind = KEY_STYLE;
      act.style_set[STY_UNDERLINE] = 1'b1;
    end else if (c == CH_O) begin
      act.kind = KEY_STYLE;
      act.style_set[STY_ITALIC] = 1'b1;
    end
    return act;
  endfunction

endpackage

`default_nettype wire

// File: rtl/utf8_styled_text_decoder.sv
// Path: a byte is taken into input register s1, decoded there, and its result loaded into the result register.
// Throughput: one byte per clock unless the output stalls; the decoder state
// sits in a single register stage that updates once per byte.
// Reset (rst, synchronous): both stages go empty, the decoder state clears
// and the colour returns to white (15) with no styles.
// ---------------------------------------------------------------------------
// utf8_styled_text_decoder
// Lenient UTF-8 decoder with section-sign formatting escapes. One byte in,
// zero or one styled character out; the final byte always gives a result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "utf8_styled_text_decoder_assert.svh"

module utf8_styled_text_decoder
  import utf8std_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // byte request
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          text_byte,
  input  wire logic                final_byte,
  // character result
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     char_valid,
  output logic [CP_W-1:0]          code_point,
  output logic [COLOUR_W-1:0]      colour_index,
  output logic                     bold_on,
  output logic                     strike_on,
  output logic                     underline_on,
  output logic                     italic_on,
  output logic                     end_of_text,
  output logic                     cut_short
);

  // ---- handshake ---------------------------------------------------------
  // Input register s1 feeds the decode; the result register takes a new
  // value when empty or being drained; a byte moves each cycle unless stalled.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_final;
  logic       out_load;
  logic       in_fire;
  logic       s1_fire;

  assign out_load = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_load;
  assign in_fire  = in_valid && in_ready;
  assign s1_fire  = s1_valid && out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte  <= text_byte;
      s1_final <= final_byte;
    end
  end

  // ---- decoder state -----------------------------------------------------
  logic [1:0]          bytes_left,     bytes_left_next;
  logic [CP_W-1:0]     code_accum,     code_accum_next;
  logic                await_key,      await_key_next;
  logic [COLOUR_W-1:0] current_colour, current_colour_next;
  logic [STYLE_W-1:0]  style_flags,    style_flags_next;

  // ---- single-pass decode ------------------------------------------------
  key_act_t        key;
  logic            have;
  logic [CP_W-1:0] cp;
  logic            is_esc;
  logic            emit;
  logic            cut;
  logic            has_result;

  assign key = decode_key(s1_byte);

  always_comb begin
    bytes_left_next     = bytes_left;
    code_accum_next     = code_accum;
    await_key_next      = await_key;
    current_colour_next = current_colour;
    style_flags_next    = style_flags;
    have                = 1'b0;
    cp                  = '0;

    if (await_key) begin
      // key byte is consumed raw, never decoded as UTF-8
      await_key_next = 1'b0;
      unique case (key.kind)
        KEY_COLOUR: begin
          current_colour_next = key.colour;
          style_flags_next    = '0;
        end
        KEY_STYLE:  style_flags_next = style_flags | key.style_set;
        KEY_NOP:    ;
        KEY_RESET: begin
          current_colour_next = COLOUR_WHITE;
          style_flags_next    = '0;
        end
        default: ;
      endcase
    end else if (bytes_left != 2'd0) begin
      // continuation: top bits are not checked
      code_accum_next = {code_accum[CP_W-7:0], s1_byte[5:0]};
      bytes_left_next = bytes_left - 2'd1;
      if (bytes_left == 2'd1) begin
        have = 1'b1;
        cp   = code_accum_next;
      end
    end else if (!s1_byte[7]) begin
      have = 1'b1;
      cp   = CP_W'(s1_byte);
    end else if (s1_byte[7:5] == 3'b110) begin
      code_accum_next = CP_W'(s1_byte[4:0]);
      bytes_left_next = 2'd1;
    end else if (s1_byte[7:4] == 4'b1110) begin
      code_accum_next = CP_W'(s1_byte[3:0]);
      bytes_left_next = 2'd2;
    end else if (s1_byte[7:3] == 5'b11110) begin
      code_accum_next = CP_W'(s1_byte[2:0]);
      bytes_left_next = 2'd3;
    end else begin
      // stray continuation or 11111xxx passes through
      have = 1'b1;
      cp   = CP_W'(s1_byte);
    end

    // section sign not at the end opens an escape
    is_esc = have && (cp == ESC_CP) && !s1_final;
    if (is_esc) begin
      await_key_next = 1'b1;
    end
    emit       = have && !is_esc;
    cut        = s1_final && (bytes_left_next != 2'd0);
    has_result = emit || s1_final;

    // end of string: everything back to reset
    if (s1_final) begin
      bytes_left_next     = '0;
      code_accum_next     = '0;
      await_key_next      = 1'b0;
      current_colour_next = COLOUR_WHITE;
      style_flags_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left     <= '0;
      code_accum     <= '0;
      await_key      <= 1'b0;
      current_colour <= COLOUR_WHITE;
      style_flags    <= '0;
    end else if (s1_fire) begin
      bytes_left     <= bytes_left_next;
      code_accum     <= code_accum_next;
      await_key      <= await_key_next;
      current_colour <= current_colour_next;
      style_flags    <= style_flags_next;
    end
  end

  // ---- result register ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_fire && has_result;
    end
  end

  // character fields are zero when no character goes out
  always_ff @(posedge clk) begin
    if (s1_fire && has_result) begin
      char_valid   <= emit;
      code_point   <= emit ? cp : '0;
      colour_index <= emit ? current_colour : '0;
      bold_on      <= emit && style_flags[STY_BOLD];
      strike_on    <= emit && style_flags[STY_STRIKE];
      underline_on <= emit && style_flags[STY_UNDERLINE];
      italic_on    <= emit && style_flags[STY_ITALIC];
      end_of_text  <= s1_final;
      cut_short    <= cut;
    end
  end

  // ---- assertions ----------------------------------------------------------
  `U8S_ASSERT_NOW(a_key_not_mid_seq, await_key, bytes_left == 2'd0,
                  "escape pending inside a multibyte sequence")
  `U8S_ASSERT_NOW(a_cut_only_at_end, out_valid && cut_short,
                  end_of_text && !char_valid, "cut_short without clean end of text")
  `U8S_ASSERT_NOW(a_empty_fields_zero, out_valid && !char_valid,
                  code_point == '0 && colour_index == '0 && !bold_on && !italic_on,
                  "result without character carries nonzero fields")
  `U8S_ASSERT_NEXT(a_final_resets, s1_fire && s1_final,
                   bytes_left == 2'd0 && !await_key && current_colour == COLOUR_WHITE
                   && style_flags == '0, "state not cleared after final byte")

endmodule

`default_nettype wire

// File: verif/utf8_styled_text_decoder_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// utf8_styled_text_decoder_test
// Streams UTF-8 strings with formatting escapes into the decoder. Random
// gaps on both handshakes, plus one long output hold-off that backs the
// pipe up. Each output request is checked against a behavioral decoder.
// ---------------------------------------------------------------------------
module utf8_styled_text_decoder_test;
  import utf8std_pkg::*;

  localparam int         RANDOM_BYTES = 400;
  localparam int         HOLD_AT      = 180;   // accepted requests before the hold-off
  localparam int         HOLD_CYCLES  = 300;
  localparam int         MAX_REPORTS  = 10;
  localparam logic [7:0] SECT_RAW     = 8'hA7; // stray continuation byte, decodes to 167
  localparam logic [7:0] KEY_R        = "r";

  // one byte request as the sender presents it
  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } text_req_t;

  // one decoded, styled character (or end-of-string marker)
  typedef struct packed {
    logic                char_valid;
    logic [CP_W-1:0]     code_point;
    logic [COLOUR_W-1:0] colour_index;
    logic                bold_on;
    logic                strike_on;
    logic                underline_on;
    logic                italic_on;
    logic                end_of_text;
    logic                cut_short;
  } styled_char_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          text_byte = 8'h00;
  logic                final_byte = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                char_valid;
  logic [CP_W-1:0]     code_point;
  logic [COLOUR_W-1:0] colour_index;
  logic                bold_on;
  logic                strike_on;
  logic                underline_on;
  logic                italic_on;
  logic                end_of_text;
  logic                cut_short;

  text_req_t    text_req_q[$];     // requests not yet presented
  styled_char_t styled_chars_q[$]; // predicted output, oldest first

  // decoder state mirrored by the predictor
  logic [1:0]          cont_left  = '0;
  logic [CP_W-1:0]     cp_accum   = '0;
  logic                key_next   = 1'b0;
  logic [COLOUR_W-1:0] cur_colour = COLOUR_WHITE;
  logic [STYLE_W-1:0]  cur_styles = '0;

  int errors    = 0;
  int sent_cnt  = 0;
  int tx_gap    = 0;
  int tx_calm   = 0;
  int rx_wait   = 0;
  int rx_calm   = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  utf8_styled_text_decoder uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .final_byte   (final_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .char_valid   (char_valid),
    .code_point   (code_point),
    .colour_index (colour_index),
    .bold_on      (bold_on),
    .strike_on    (strike_on),
    .underline_on (underline_on),
    .italic_on    (italic_on),
    .end_of_text  (end_of_text),
    .cut_short    (cut_short)
  );

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Behavioral decoder
  // -------------------------------------------------------------------------

  // Formatting key: ASCII lower-cased, then colour / style / no-op / white.
  task automatic apply_format_key(input logic [7:0] k);
    logic [7:0] lc;
    lc = ((k >= CH_UP_A) && (k <= CH_UP_Z)) ? 8'(k + CASE_OFS) : k;
    if ((lc >= CH_0) && (lc <= CH_9)) begin
      cur_colour = COLOUR_W'(lc - CH_0);
      cur_styles = '0;
    end else if ((lc >= CH_A) && (lc <= CH_F)) begin
      cur_colour = COLOUR_W'(lc - CH_A + 8'd10);
      cur_styles = '0;
    end else if (lc == CH_K) begin
      // k: leaves everything alone
    end else if (lc == CH_L) begin
      cur_styles[STY_BOLD] = 1'b1;
    end else if (lc == CH_M) begin
      cur_styles[STY_STRIKE] = 1'b1;
    end else if (lc == CH_N) begin
      cur_styles[STY_UNDERLINE] = 1'b1;
    end else if (lc == CH_O) begin
      cur_styles[STY_ITALIC] = 1'b1;
    end else begin
      // r and every unknown key
      cur_colour = COLOUR_WHITE;
      cur_styles = '0;
    end
  endtask

  // Advance the decoder by one accepted byte; queue the output it causes.
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    styled_char_t sc;
    logic         have;
    logic [CP_W-1:0] cp;
    sc   = '0;
    have = 1'b0;
    cp   = '0;
    if (key_next) begin
      // key byte is consumed raw, even when it looks like a lead byte
      key_next = 1'b0;
      apply_format_key(b);
    end else if (cont_left != 2'd0) begin
      // continuation: top bits ignored, low six bits shifted in
      cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        have = 1'b1;
        cp   = cp_accum;
      end
    end else if (!b[7]) begin
      have = 1'b1;
      cp   = CP_W'(b);
    end else if (b[7:5] == 3'b110) begin
      cp_accum  = CP_W'(b[4:0]);
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cp_accum  = CP_W'(b[3:0]);
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      cp_accum  = CP_W'(b[2:0]);
      cont_left = 2'd3;
    end else begin
      // stray continuation or 11111xxx: passes through as its own value
      have = 1'b1;
      cp   = CP_W'(b);
    end

    // section sign mid-string opens a formatting key; on the last byte it prints
    if (have && (cp == ESC_CP) && !fin) begin
      key_next = 1'b1;
      have     = 1'b0;
    end

    if (have) begin
      sc.char_valid   = 1'b1;
      sc.code_point   = cp;
      sc.colour_index = cur_colour;
      sc.bold_on      = cur_styles[STY_BOLD];
      sc.strike_on    = cur_styles[STY_STRIKE];
      sc.underline_on = cur_styles[STY_UNDERLINE];
      sc.italic_on    = cur_styles[STY_ITALIC];
    end
    sc.end_of_text = fin;
    sc.cut_short   = fin && (cont_left != 2'd0);
    if (have || fin)
      styled_chars_q.push_back(sc);

    if (fin) begin
      cont_left  = '0;
      cp_accum   = '0;
      key_next   = 1'b0;
      cur_colour = COLOUR_WHITE;
      cur_styles = '0;
    end
  endtask

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  // Idle length: mostly none, some short, a few long; occasional calm runs.
  function automatic int gap_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_req(input logic [7:0] b, input logic fin);
    text_req_t r;
    r.b   = b;
    r.fin = fin;
    text_req_q.push_back(r);
  endtask

  // lead byte of a sequence carrying 'need' continuation bytes
  function automatic logic [7:0] lead_byte(input int need);
    logic [7:0] b;
    b = 8'($urandom);
    case (need)
      1:       b = {3'b110, b[4:0]};
      2:       b = {4'b1110, b[3:0]};
      default: b = {5'b11110, b[2:0]};
    endcase
    return b;
  endfunction

  // continuation byte, now and then with top bits that are not 10
  function automatic logic [7:0] cont_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if ($urandom_range(0, 9) != 0)
      b[7:6] = 2'b10;
    return b;
  endfunction

  // mostly a valid key in either case, sometimes any byte at all
  function automatic logic [7:0] key_byte();
    int         idx;
    logic [7:0] k;
    if ($urandom_range(0, 9) < 3)
      return 8'($urandom);
    idx = $urandom_range(0, 21);
    if (idx < 10)
      k = 8'(CH_0 + idx);
    else if (idx < 16)
      k = 8'(CH_A + idx - 10);
    else if (idx < 21)
      k = 8'(CH_K + idx - 16);
    else
      k = KEY_R;
    if ((k >= CH_A) && $urandom_range(0, 1))
      k = 8'(k - CASE_OFS);
    return k;
  endfunction

  // One random string: a run of tokens, sometimes cut off inside a sequence.
  task automatic add_string();
    logic [7:0] seq[$];
    int         n_tok;
    int         kind;
    int         need;
    n_tok = $urandom_range(1, 12);
    for (int t = 0; t < n_tok; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        seq.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 57) begin
        // escape: raw A7, 2-byte, or overlong 3-byte section sign, then key
        case ($urandom_range(0, 3))
          0, 1: seq.push_back(SECT_RAW);
          2: begin
            seq.push_back(8'hC2);
            seq.push_back(SECT_RAW);
          end
          default: begin
            seq.push_back(8'hE0);
            seq.push_back(8'h82);
            seq.push_back(SECT_RAW);
          end
        endcase
        seq.push_back(key_byte());
      end else if (kind < 85) begin
        need = $urandom_range(1, 3);
        seq.push_back(lead_byte(need));
        repeat (need) seq.push_back(cont_byte());
      end else if (kind < 95) begin
        // stray continuation or an invalid 11111xxx lead
        seq.push_back($urandom_range(0, 1) ? 8'($urandom_range(128, 191))
                                           : 8'($urandom_range(248, 255)));
      end else begin
        // bare section sign: whatever follows becomes the key
        seq.push_back(SECT_RAW);
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      need = $urandom_range(1, 3);
      seq.push_back(lead_byte(need));
      repeat ($urandom_range(0, need - 1)) seq.push_back(cont_byte());
    end
    foreach (seq[i])
      push_req(seq[i], i == seq.size() - 1);
  endtask

  // -------------------------------------------------------------------------
  // Reset, stimulus and end of run
  // -------------------------------------------------------------------------
  initial begin
    // directed string 1: extremes, stray bytes, all key kinds, 21-bit max
    push_req(8'h00, 1'b0);
    push_req(8'h7F, 1'b0);
    push_req(8'hFF, 1'b0);          // 11111xxx passes through
    push_req(8'h80, 1'b0);          // stray continuation
    push_req(8'hC2, 1'b0);          // 2-byte section sign -> escape
    push_req(SECT_RAW, 1'b0);
    push_req("L", 1'b0);            // upper-case bold
    push_req(SECT_RAW, 1'b0);
    push_req(CH_O, 1'b0);           // italic on top of bold
    push_req(8'hE2, 1'b0);          // euro sign, styled
    push_req(8'h82, 1'b0);
    push_req(8'hAC, 1'b0);
    push_req(SECT_RAW, 1'b0);
    push_req(CH_K, 1'b0);           // no effect
    push_req(SECT_RAW, 1'b0);
    push_req(8'hE2, 1'b0);          // lead-looking key: unknown, white
    push_req(SECT_RAW, 1'b0);
    push_req("C", 1'b0);            // colour 12
    push_req(8'hF7, 1'b0);          // 0x1FFFFF
    push_req(8'hBF, 1'b0);
    push_req(8'hBF, 1'b0);
    push_req(8'hBF, 1'b0);
    push_req(SECT_RAW, 1'b1);       // section sign on the last byte prints
    // directed string 2: cut short inside a 4-byte sequence
    push_req(8'hF0, 1'b0);
    push_req(8'h9F, 1'b1);
    // directed string 3: r key, then a byte-zero key ends the string
    push_req(SECT_RAW, 1'b0);
    push_req(KEY_R, 1'b0);
    push_req(SECT_RAW, 1'b0);
    push_req(8'h00, 1'b1);

    while (text_req_q.size() < RANDOM_BYTES + 29)
      add_string();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // every request taken, then every prediction matched, then drain time
    while ((text_req_q.size() != 0) || in_valid)
      @(posedge clk);
    while (styled_chars_q.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Driver: presents queued byte requests; predicts at each acceptance
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        decode_byte(text_byte, final_byte);
        sent_cnt <= sent_cnt + 1;
      end
      if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap   <= tx_gap - 1;
      end else if (text_req_q.size() != 0) begin
        in_valid   <= 1'b1;
        text_byte  <= text_req_q[0].b;
        final_byte <= text_req_q[0].fin;
        text_req_q.pop_front();
        tx_gap     <= gap_len(tx_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // One long output hold-off once traffic is flowing; the sender keeps
  // offering, so the decoder fills and drops in_ready.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && (sent_cnt >= HOLD_AT)) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: random output stalls, compare against oldest prediction
  // -------------------------------------------------------------------------
  function automatic string fmt_char(input styled_char_t sc);
    return $sformatf("vld=%0d cp=%06h col=%0d b/s/u/i=%0d%0d%0d%0d eot=%0d cut=%0d",
                     sc.char_valid, sc.code_point, sc.colour_index, sc.bold_on,
                     sc.strike_on, sc.underline_on, sc.italic_on, sc.end_of_text,
                     sc.cut_short);
  endfunction

  task automatic check_output();
    styled_char_t got;
    styled_char_t want;
    got = '{char_valid, code_point, colour_index, bold_on, strike_on,
            underline_on, italic_on, end_of_text, cut_short};
    if (styled_chars_q.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: output with nothing expected: %s", $realtime, fmt_char(got));
    end else begin
      want = styled_chars_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch\n  expected %s\n  actual   %s",
                   $realtime, fmt_char(want), fmt_char(got));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else begin
      if (out_valid && out_ready)
        check_output();
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (rx_wait != 0) begin
        out_ready <= 1'b0;
        rx_wait   <= rx_wait - 1;
      end else if ($urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        rx_wait   <= gap_len(rx_calm);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

endmodule
